@@ rtl/pu_pkg.sv @@
package pu_pkg;

	localparam int FRAME_BITS = 16;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_TX_TICK = 2'd2,
		ACT_RX_TICK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_MODE  = 2'd0,
		PH_SYNC1 = 2'd1,
		PH_SYNC2 = 2'd2,
		PH_CMD   = 2'd3
	} phase_t;

	// command byte bits
	localparam int CMD_TXEN  = 0;
	localparam int CMD_DTR   = 1;
	localparam int CMD_RXEN  = 2;
	localparam int CMD_SBRK  = 3;
	localparam int CMD_ER    = 4;
	localparam int CMD_RTS   = 5;
	localparam int CMD_IR    = 6;

	localparam logic [1:0] BAUD_X16 = 2'd2;
	localparam logic [1:0] BAUD_X64 = 2'd3;
	localparam logic [1:0] BAUD_SYNC = 2'd0;

	typedef struct packed {
		action_t    action;
		logic       control_select;
		logic [7:0] write_data;
		logic       rxd;
		logic       clear_to_send;
		logic       data_set_ready;
	} pu_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_line;
		logic       request_to_send;
		logic       terminal_ready;
		logic       rx_ready;
		logic       tx_ready;
		logic       tx_empty;
	} pu_result_t;

	typedef struct packed {
		phase_t                  setup_phase;
		logic                    sync_format;
		logic [1:0]              baud_code;
		logic [3:0]              char_length;
		logic                    parity_on;
		logic                    parity_even;
		logic [1:0]              stop_count;
		logic                    single_sync;
		logic [1:0][7:0]         sync_chars;
		logic [7:0]              command_bits;
		logic                    txrdy;
		logic                    rxrdy;
		logic                    txe;
		logic                    pe;
		logic                    oe;
		logic                    fe;
		logic [FRAME_BITS-1:0]   tx_frame;
		logic [CNT_W-1:0]        tx_bits_left;
		logic [6:0]              tx_divider;
		logic                    tx_level;
		logic                    rx_active;
		logic [FRAME_BITS-1:0]   rx_frame;
		logic [CNT_W-1:0]        rx_bits_got;
		logic [6:0]              rx_divider;
		logic [7:0]              rx_byte;
	} pu_state_t;

	localparam pu_state_t ST_RESET = '{
		setup_phase: PH_MODE,
		txrdy:       1'b1,
		txe:         1'b1,
		tx_level:    1'b1,
		default:     '0
	};

	function automatic logic [7:0] data_mask(input logic [3:0] n);
		logic [7:0] m;
		if (n >= 4'd8) begin
			m = 8'hFF;
		end else begin
			m = 8'((9'd1 << n) - 9'd1);
		end
		return m;
	endfunction

	function automatic logic parity_calc(input logic [7:0] d, input logic [3:0] n,
			input logic even);
		logic x;
		x = ^(d & data_mask(n));
		return even ? x : ~x;
	endfunction

endpackage

@@ rtl/pu_core.sv @@
module pu_core import pu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  pu_item_t   item,
	output pu_result_t result
);

	pu_state_t             st_q;
	pu_state_t             nx;
	logic [7:0]            rd;
	logic [3:0]            n;
	logic [7:0]            mask;
	logic [1:0]            stops;
	logic [6:0]            div;
	logic [7:0]            d;
	logic [FRAME_BITS-1:0] f;
	logic [CNT_W-1:0]      len;
	logic [FRAME_BITS-1:0] rf;
	logic [CNT_W-1:0]      got;
	logic [CNT_W-1:0]      base;
	logic [CNT_W-1:0]      need;
	logic [FRAME_BITS-1:0] sh;
	logic [FRAME_BITS-1:0] psh;
	logic [7:0]            rx_data;
	logic                  stop_ok;

	always_comb begin
		n     = (st_q.char_length > 4'd8) ? 4'd8 : st_q.char_length;
		mask  = data_mask(n);
		stops = (st_q.stop_count == 2'd0) ? 2'd1 : st_q.stop_count;
		case (st_q.baud_code)
			BAUD_X16: div = 7'd16;
			BAUD_X64: div = 7'd64;
			default:  div = 7'd1;
		endcase

		// transmit frame build
		d   = item.write_data & mask;
		len = st_q.sync_format ? CNT_W'(0) : CNT_W'(1);
		f   = FRAME_BITS'(d) << len;
		len = len + CNT_W'(n);
		if (st_q.parity_on) begin
			f   = f | (FRAME_BITS'(parity_calc(d, n, st_q.parity_even)) << len);
			len = len + CNT_W'(1);
		end
		if (!st_q.sync_format) begin
			f   = f | (FRAME_BITS'(1) << len);
			len = len + CNT_W'(1);
			if (stops == 2'd2) begin
				f   = f | (FRAME_BITS'(1) << len);
				len = len + CNT_W'(1);
			end
		end

		// receive sample
		rf  = st_q.rx_frame;
		got = st_q.rx_bits_got;
		if (st_q.rx_bits_got < CNT_W'(FRAME_BITS)) begin
			rf  = st_q.rx_frame | (FRAME_BITS'(item.rxd) << st_q.rx_bits_got);
			got = st_q.rx_bits_got + CNT_W'(1);
		end
		base    = CNT_W'(1) + CNT_W'(n) + CNT_W'(st_q.parity_on);
		need    = base + CNT_W'(stops);
		sh      = rf >> base;
		psh     = rf >> (CNT_W'(1) + CNT_W'(n));
		stop_ok = sh[0] && (stops == 2'd1 || sh[1]);
		rx_data = 8'(rf >> 1) & mask;

		nx = st_q;
		rd = 8'd0;
		if (step) begin
			case (item.action)
				ACT_WRITE: begin
					if (!item.control_select) begin
						if (st_q.command_bits[CMD_TXEN]) begin
							nx.tx_frame     = f;
							nx.tx_bits_left = len;
							nx.txrdy        = 1'b0;
							nx.txe          = 1'b0;
						end
					end else begin
						case (st_q.setup_phase)
							PH_MODE: begin
								nx.char_length = 4'd5 + {2'b00, item.write_data[3:2]};
								nx.parity_on   = item.write_data[4];
								nx.parity_even = item.write_data[5];
								if (item.write_data[1:0] == 2'b00) begin
									nx.sync_format = 1'b1;
									nx.baud_code   = BAUD_SYNC;
									nx.single_sync = item.write_data[7];
									nx.setup_phase = PH_SYNC1;
								end else begin
									nx.sync_format = 1'b0;
									nx.baud_code   = item.write_data[1:0];
									nx.stop_count  = item.write_data[7] ? 2'd2 : 2'd1;
									nx.setup_phase = PH_CMD;
								end
							end
							PH_SYNC1: begin
								nx.sync_chars[0] = item.write_data;
								nx.setup_phase   = st_q.single_sync ? PH_CMD : PH_SYNC2;
							end
							PH_SYNC2: begin
								nx.sync_chars[1] = item.write_data;
								nx.setup_phase   = PH_CMD;
							end
							default: begin
								nx.command_bits = item.write_data;
								if (item.write_data[CMD_ER] || item.write_data[CMD_IR]) begin
									nx.pe = 1'b0;
									nx.oe = 1'b0;
									nx.fe = 1'b0;
								end
								if (item.write_data[CMD_IR]) begin
									nx.setup_phase  = PH_MODE;
									nx.rxrdy        = 1'b0;
									nx.txrdy        = 1'b1;
									nx.txe          = 1'b1;
									nx.tx_frame     = '0;
									nx.tx_bits_left = '0;
									nx.tx_level     = 1'b1;
									nx.tx_divider   = '0;
									nx.rx_active    = 1'b0;
									nx.rx_frame     = '0;
									nx.rx_bits_got  = '0;
									nx.rx_divider   = '0;
								end
							end
						endcase
					end
				end
				ACT_READ: begin
					if (item.control_select) begin
						rd = {item.data_set_ready, 1'b0, st_q.fe, st_q.oe, st_q.pe,
							st_q.txe, st_q.rxrdy, st_q.txrdy};
					end else begin
						rd       = st_q.rx_byte;
						nx.rxrdy = 1'b0;
					end
				end
				ACT_TX_TICK: begin
					if (!st_q.command_bits[CMD_TXEN]) begin
						nx.tx_level   = 1'b1;
						nx.tx_divider = '0;
					end else if (st_q.command_bits[CMD_SBRK]) begin
						nx.tx_level   = 1'b0;
						nx.txrdy      = 1'b0;
						nx.txe        = 1'b0;
						nx.tx_divider = '0;
					end else if (!st_q.sync_format && !item.clear_to_send) begin
						nx.tx_level = 1'b1;
						nx.txrdy    = 1'b0;
						nx.txe      = 1'b0;
					end else if (!st_q.sync_format && (st_q.tx_divider + 7'd1) < div) begin
						nx.tx_divider = st_q.tx_divider + 7'd1;
					end else begin
						nx.tx_divider = '0;
						if (st_q.tx_bits_left == '0) begin
							nx.tx_level = 1'b1;
							nx.txrdy    = 1'b1;
							nx.txe      = 1'b1;
						end else begin
							nx.tx_level     = st_q.tx_frame[0];
							nx.tx_frame     = st_q.tx_frame >> 1;
							nx.tx_bits_left = st_q.tx_bits_left - CNT_W'(1);
							if (st_q.tx_bits_left == CNT_W'(1)) begin
								nx.tx_level = 1'b1;
								nx.txrdy    = 1'b1;
								nx.txe      = 1'b1;
							end
						end
					end
				end
				default: begin
					if (!st_q.command_bits[CMD_RXEN] || st_q.sync_format || !st_q.rx_active) begin
						nx.rx_active   = 1'b0;
						nx.rx_frame    = '0;
						nx.rx_bits_got = '0;
						nx.rx_divider  = '0;
						if (st_q.command_bits[CMD_RXEN] && !st_q.sync_format && !item.rxd) begin
							nx.rx_active   = 1'b1;
							nx.rx_bits_got = CNT_W'(1);
						end
					end else if ((st_q.rx_divider + 7'd1) < div) begin
						nx.rx_divider = st_q.rx_divider + 7'd1;
					end else begin
						nx.rx_divider  = '0;
						nx.rx_frame    = rf;
						nx.rx_bits_got = got;
						if (got >= need) begin
							if (rf[0]) begin
								nx.fe = 1'b1;
							end else if (st_q.rxrdy) begin
								nx.oe = 1'b1;
							end else begin
								nx.rx_byte = rx_data;
								nx.rxrdy   = 1'b1;
								if (st_q.parity_on &&
										parity_calc(rx_data, n, st_q.parity_even) != psh[0]) begin
									nx.pe = 1'b1;
								end
								if (!stop_ok) begin
									nx.fe = 1'b1;
								end
							end
							nx.rx_active   = 1'b0;
							nx.rx_frame    = '0;
							nx.rx_bits_got = '0;
						end
					end
				end
			endcase
		end

		result.read_data       = rd;
		result.tx_line         = nx.tx_level;
		result.request_to_send = nx.command_bits[CMD_RTS];
		result.terminal_ready  = nx.command_bits[CMD_DTR];
		result.rx_ready        = nx.rxrdy;
		result.tx_ready        = nx.txrdy;
		result.tx_empty        = nx.txe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else begin
			st_q <= nx;
		end
	end

endmodule

@@ rtl/programmable_usart_top.sv @@
// Flow: a request accepted into the input register has its result loaded
// into the result register when the pipeline advances (setting out_valid);
// that load waits while a held result is not yet taken (out_ready low).
// Throughput: one request per cycle while no held result waits on out_ready;
// the result register stalls on out_ready. Reset: arst_n asynchronously clears
// valid flags and core state (tx idles high, tx_ready and tx_empty set, setup expects a mode byte), not data regs.
module programmable_usart_top import pu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic       control_select,
	input  logic [7:0] write_data,
	input  logic       rxd,
	input  logic       clear_to_send,
	input  logic       data_set_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       tx_line,
	output logic       request_to_send,
	output logic       terminal_ready,
	output logic       rx_ready,
	output logic       tx_ready,
	output logic       tx_empty
);

	pu_item_t   item_s1;
	logic       valid_s1;
	pu_result_t res_q;
	logic       out_valid_q;
	pu_result_t res_d;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action: action_t'(action), control_select: control_select,
				write_data: write_data, rxd: rxd, clear_to_send: clear_to_send,
				data_set_ready: data_set_ready};
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	pu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res_d)
	);

	assign out_valid       = out_valid_q;
	assign read_data       = res_q.read_data;
	assign tx_line         = res_q.tx_line;
	assign request_to_send = res_q.request_to_send;
	assign terminal_ready  = res_q.terminal_ready;
	assign rx_ready        = res_q.rx_ready;
	assign tx_ready        = res_q.tx_ready;
	assign tx_empty        = res_q.tx_empty;

endmodule

@@ rtl/pu_checker.sv @@
module pu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       tx_ready,
	input logic       tx_empty
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request blocked while results drain");

	a_tx_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tx_ready == tx_empty))
		else $error("tx ready and tx empty disagree");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("stalled result changed");

endmodule

bind programmable_usart_top pu_checker u_pu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.tx_ready  (tx_ready),
	.tx_empty  (tx_empty)
);
